// ----- src/sde_pkg.sv -----
// Shared types, constants and a helper function for the stereo disparity energy core.
package sde_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_OUTLIER_WEIGHT  = 3'd0;
    localparam logic [2:0] REG_INV_COLOR_SCALE = 3'd1;
    localparam logic [2:0] REG_SMOOTH_CAP      = 3'd2;
    localparam logic [2:0] REG_SMOOTH_SLOPE    = 3'd3;
    localparam logic [2:0] REG_OCC_PENALTY     = 3'd4;

    // Reset values of the configuration registers
    localparam logic [15:0] RST_OUTLIER_WEIGHT  = 16'd655;
    localparam logic [15:0] RST_INV_COLOR_SCALE = 16'd3277;
    localparam logic [15:0] RST_SMOOTH_CAP      = 16'd2048;
    localparam logic [15:0] RST_SMOOTH_SLOPE    = 16'd1024;
    localparam logic [15:0] RST_OCC_PENALTY     = 16'd1024;

    localparam logic [15:0] ENERGY_MAX = 16'hFFFF;
    localparam logic [31:0] LN2_Q32    = 32'd2977044472;
    localparam logic [31:0] EXP_STEP0  = 32'd4290775039;

    // Back pipeline stage map
    localparam int SQRT_STEPS = 19;
    localparam int EXP_STEPS  = 15;
    localparam int NORM_STEPS = 5;
    localparam int LOG_STEPS  = 16;
    localparam int ST_SCALE   = SQRT_STEPS;
    localparam int ST_EXP0    = ST_SCALE + 1;
    localparam int ST_MIX     = ST_EXP0 + EXP_STEPS;
    localparam int ST_NORM0   = ST_MIX + 1;
    localparam int ST_LOG0    = ST_NORM0 + NORM_STEPS;
    localparam int ST_LN      = ST_LOG0 + LOG_STEPS;
    localparam int ST_OUT     = ST_LN + 1;
    localparam int NSTAGE     = ST_OUT + 1;

    typedef struct packed {
        logic [15:0] outlier_weight;
        logic [15:0] inverse_color_scale;
        logic [15:0] smooth_cap;
        logic [15:0] smooth_slope;
        logic [15:0] occluded_match_penalty;
    } cfg_t;

    // Per-item control that rides along the back pipeline
    typedef struct packed {
        logic        pair;
        logic        visible;
        logic        occluded;
        logic [15:0] pair_energy;
    } side_t;

    // One classified item in the queue
    typedef struct packed {
        side_t       side;
        logic [17:0] dist_sq;
    } item_t;

    // exp(-2^k/1024) in Q0.32, by repeated rounded squaring
    function automatic logic [31:0] exp_step(input int k);
        logic [63:0] t;
        t = {32'd0, EXP_STEP0};
        for (int i = 0; i < k; i++) begin
            t = (t * t + 64'h8000_0000) >> 32;
        end
        return t[31:0];
    endfunction

endpackage

// ----- src/sde_front.sv -----
// Front part: classifies a factor and does the cheap per-item arithmetic.
module sde_front #(
    parameter int LABEL_COUNT = 64
) (
    input  logic               factor_kind,
    input  logic [5:0]         label_a,
    input  logic [5:0]         label_b,
    input  logic [7:0]         own_red,
    input  logic [7:0]         own_green,
    input  logic [7:0]         own_blue,
    input  logic [7:0]         match_red,
    input  logic [7:0]         match_green,
    input  logic [7:0]         match_blue,
    input  logic               pixel_visible,
    input  logic               match_occluded,
    input  logic               same_occlusion,
    input  sde_pkg::cfg_t      cfg,
    output sde_pkg::item_t     item
);
    localparam int LabelMax = LABEL_COUNT - 1;

    logic [7:0]  dr, dg, db;
    logic [17:0] dist_sq;
    logic [5:0]  la, lb, ld;
    logic [21:0] lin;
    logic [15:0] pair_energy;

    // squared color distance
    always_comb
    begin
        dr = (own_red   > match_red)   ? own_red   - match_red   : match_red   - own_red;
        dg = (own_green > match_green) ? own_green - match_green : match_green - own_green;
        db = (own_blue  > match_blue)  ? own_blue  - match_blue  : match_blue  - own_blue;
        dist_sq = 18'(16'(dr * dr)) + 18'(16'(dg * dg)) + 18'(16'(db * db));
    end

    // truncated linear smoothness, zero when same_occlusion is low
    always_comb
    begin
        la = (int'(label_a) > LabelMax) ? 6'(LabelMax) : label_a;
        lb = (int'(label_b) > LabelMax) ? 6'(LabelMax) : label_b;
        ld = (la > lb) ? la - lb : lb - la;
        lin = 22'(cfg.smooth_slope) * 22'(ld);
        if (!same_occlusion)
            pair_energy = '0;
        else if (lin < 22'(cfg.smooth_cap))
            pair_energy = lin[15:0];
        else
            pair_energy = cfg.smooth_cap;
    end

    always_comb
    begin
        item.side.pair        = factor_kind;
        item.side.visible     = pixel_visible;
        item.side.occluded    = match_occluded;
        item.side.pair_energy = pair_energy;
        item.dist_sq          = dist_sq;
    end

endmodule

// ----- src/sde_queue.sv -----
// Two-entry queue between the front and the back pipeline.
module sde_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  sde_pkg::item_t  push_item,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output sde_pkg::item_t  head_item
);
    sde_pkg::item_t mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_item  = mem_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

// ----- src/sde_back.sv -----
// Back pipeline: sqrt, exp, mixing, -ln and final energy, one item per cycle unless stalled.
module sde_back (
    input  logic            clk,
    input  logic            rst_n,
    input  sde_pkg::cfg_t   cfg,
    input  logic            head_valid,
    input  sde_pkg::item_t  head_item,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [15:0]     energy
);
    localparam int NS = sde_pkg::NSTAGE;

    logic                 en;
    logic [NS-1:0]        vld_reg;
    sde_pkg::side_t       side_reg [NS];

    assign en        = !vld_reg[sde_pkg::ST_OUT] || out_ready;
    assign pop       = en && head_valid;
    assign out_valid = vld_reg[sde_pkg::ST_OUT];

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NS-2:0], head_valid};
    end

    // sideband travels with the item
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= head_item.side;
            for (int i = 1; i < NS; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    // digit-by-digit square root of dist_sq * 2^20
    logic [37:0] rem_reg  [sde_pkg::SQRT_STEPS];
    logic [37:0] root_reg [sde_pkg::SQRT_STEPS];

    for (genvar gi = 0; gi < sde_pkg::SQRT_STEPS; gi++)
    begin : g_sqrt
        localparam logic [37:0] BitV = 38'd1 << (36 - 2 * gi);
        logic [37:0] rin, oin, trial;
        if (gi == 0)
        begin : g_first
            assign rin = {head_item.dist_sq, 20'd0};
            assign oin = '0;
        end
        else
        begin : g_rest
            assign rin = rem_reg[gi-1];
            assign oin = root_reg[gi-1];
        end
        assign trial = oin + BitV;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rin >= trial)
                begin
                    rem_reg[gi]  <= rin - trial;
                    root_reg[gi] <= (oin >> 1) + BitV;
                end
                else
                begin
                    rem_reg[gi]  <= rin;
                    root_reg[gi] <= oin >> 1;
                end
            end
        end
    end

    // exponent x = r * inverse_color_scale / 2^16
    logic [18:0] x_reg;
    logic [34:0] scale_prod;
    assign scale_prod = 35'(root_reg[sde_pkg::SQRT_STEPS-1][18:0])
                      * 35'(cfg.inverse_color_scale);
    always_ff @(posedge clk)
    begin
        if (en)
            x_reg <= scale_prod[34:16];
    end

    // exp(-x) by one conditional multiply per exponent bit
    logic [32:0] e_reg  [sde_pkg::EXP_STEPS];
    logic [14:0] xb_reg [sde_pkg::EXP_STEPS];

    for (genvar gk = 0; gk < sde_pkg::EXP_STEPS; gk++)
    begin : g_exp
        localparam logic [31:0] StepK = sde_pkg::exp_step(gk);
        logic [32:0] ein;
        logic [14:0] xin;
        logic [63:0] prod;
        if (gk == 0)
        begin : g_first
            assign ein = (x_reg[18:15] != 4'd0) ? 33'd0 : {1'b1, 32'd0};
            assign xin = x_reg[14:0];
        end
        else
        begin : g_rest
            assign ein = e_reg[gk-1];
            assign xin = xb_reg[gk-1];
        end
        assign prod = 64'(ein) * 64'(StepK) + 64'h8000_0000;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                xb_reg[gk] <= xin;
                e_reg[gk]  <= xin[gk] ? {1'b0, prod[63:32]} : ein;
            end
        end
    end

    // likelihood p = (1-ed)*e + ed, Q0.32
    logic [32:0] p_reg;
    logic [49:0] mix_prod;
    logic [33:0] mix_sum;
    assign mix_prod = 50'(17'h10000 - 17'(cfg.outlier_weight))
                    * 50'(e_reg[sde_pkg::EXP_STEPS-1]);
    assign mix_sum  = mix_prod[49:16] + {2'd0, cfg.outlier_weight, 16'd0};
    always_ff @(posedge clk)
    begin
        if (en)
            p_reg <= mix_sum[32:0];
    end

    // normalize p to [2^31, 2^32); c = 32 - leading bit position
    logic [31:0] ny_reg [sde_pkg::NORM_STEPS];
    logic [5:0]  nc_reg [sde_pkg::NORM_STEPS];
    logic        nz_reg [sde_pkg::NORM_STEPS];

    for (genvar gn = 0; gn < sde_pkg::NORM_STEPS; gn++)
    begin : g_norm
        localparam int Sh = 16 >> gn;
        logic [31:0] yin;
        logic [5:0]  cin;
        logic        zin;
        if (gn == 0)
        begin : g_first
            assign yin = p_reg[32] ? p_reg[32:1] : p_reg[31:0];
            assign cin = p_reg[32] ? 6'd0 : 6'd1;
            assign zin = (p_reg == 33'd0);
        end
        else
        begin : g_rest
            assign yin = ny_reg[gn-1];
            assign cin = nc_reg[gn-1];
            assign zin = nz_reg[gn-1];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                nz_reg[gn] <= zin;
                if (yin[31 -: Sh] == '0)
                begin
                    ny_reg[gn] <= yin << Sh;
                    nc_reg[gn] <= cin + 6'(Sh);
                end
                else
                begin
                    ny_reg[gn] <= yin;
                    nc_reg[gn] <= cin;
                end
            end
        end
    end

    // fractional log2 bits by repeated squaring
    logic [31:0] ly_reg [sde_pkg::LOG_STEPS];
    logic [15:0] lf_reg [sde_pkg::LOG_STEPS];
    logic [5:0]  lc_reg [sde_pkg::LOG_STEPS];
    logic        lz_reg [sde_pkg::LOG_STEPS];

    for (genvar gl = 0; gl < sde_pkg::LOG_STEPS; gl++)
    begin : g_log
        logic [31:0] yin;
        logic [15:0] fin;
        logic [5:0]  cin;
        logic        zin;
        logic [63:0] sq;
        if (gl == 0)
        begin : g_first
            assign yin = ny_reg[sde_pkg::NORM_STEPS-1];
            assign fin = '0;
            assign cin = nc_reg[sde_pkg::NORM_STEPS-1];
            assign zin = nz_reg[sde_pkg::NORM_STEPS-1];
        end
        else
        begin : g_rest
            assign yin = ly_reg[gl-1];
            assign fin = lf_reg[gl-1];
            assign cin = lc_reg[gl-1];
            assign zin = lz_reg[gl-1];
        end
        assign sq = 64'(yin) * 64'(yin);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                lc_reg[gl] <= cin;
                lz_reg[gl] <= zin;
                if (sq[63])
                begin
                    ly_reg[gl] <= sq[63:32];
                    lf_reg[gl] <= {fin[14:0], 1'b1};
                end
                else
                begin
                    ly_reg[gl] <= sq[62:31];
                    lf_reg[gl] <= {fin[14:0], 1'b0};
                end
            end
        end
    end

    // -ln(p) in Q.10: -log2 times ln 2, rounded
    logic [21:0] lq;
    logic [53:0] ln_prod;
    logic [15:0] cost_reg;
    assign lq      = {lc_reg[sde_pkg::LOG_STEPS-1], 16'd0}
                   - 22'(lf_reg[sde_pkg::LOG_STEPS-1]);
    assign ln_prod = 54'(lq) * 54'(sde_pkg::LN2_Q32) + (54'd1 << 37);
    always_ff @(posedge clk)
    begin
        if (en)
            cost_reg <= lz_reg[sde_pkg::LOG_STEPS-1] ? sde_pkg::ENERGY_MAX
                                                      : ln_prod[53:38];
    end

    // final energy with saturation
    sde_pkg::side_t fs;
    logic [16:0]    usum;
    logic [15:0]    energy_reg;
    assign fs   = side_reg[sde_pkg::ST_LN];
    assign usum = (fs.visible  ? {1'b0, cost_reg} : 17'd0)
                + (fs.occluded ? {1'b0, cfg.occluded_match_penalty} : 17'd0);
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (fs.pair)
                energy_reg <= fs.pair_energy;
            else
                energy_reg <= usum[16] ? sde_pkg::ENERGY_MAX : usum[15:0];
        end
    end
    assign energy = energy_reg;

    // a pairwise result never exceeds the smoothness cap
    a_pair_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && side_reg[sde_pkg::ST_OUT].pair |-> energy_reg <= cfg.smooth_cap)
        else $error("pairwise energy above cap");

    // unary factor with hidden pixel and visible match costs nothing
    a_unary_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !side_reg[sde_pkg::ST_OUT].pair && !side_reg[sde_pkg::ST_OUT].visible
        && !side_reg[sde_pkg::ST_OUT].occluded |-> energy_reg == 16'd0)
        else $error("unary energy should be zero");

    // a stall freezes the whole pipeline
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved during stall");

    // the queue is only drained while the pipeline advances
    a_pop_en: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> en && head_valid)
        else $error("pop without advance");

endmodule

// ----- src/stereo_disparity_energy_core.sv -----
// Throughput: one factor per cycle unless stalled; the 59-stage back pipeline advances as one.
// The pipeline stalls only while an output beat is waiting; a 2-entry queue absorbs the front.
// Reset (rst_n, async low) clears valids, queue pointers and loads the register defaults.
// Top level: stereo disparity MRF factor energy core.
module stereo_disparity_energy_core #(
    parameter int LABEL_COUNT = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        factor_kind,
    input  logic [5:0]  label_a,
    input  logic [5:0]  label_b,
    input  logic [7:0]  own_red,
    input  logic [7:0]  own_green,
    input  logic [7:0]  own_blue,
    input  logic [7:0]  match_red,
    input  logic [7:0]  match_green,
    input  logic [7:0]  match_blue,
    input  logic        pixel_visible,
    input  logic        match_occluded,
    input  logic        same_occlusion,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] energy,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    sde_pkg::cfg_t  cfg_reg;
    sde_pkg::item_t front_item, head_item;
    logic           q_full, head_valid, pop;

    assign cfg_ready = 1'b1;
    assign in_ready  = !q_full;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.outlier_weight         <= sde_pkg::RST_OUTLIER_WEIGHT;
            cfg_reg.inverse_color_scale    <= sde_pkg::RST_INV_COLOR_SCALE;
            cfg_reg.smooth_cap             <= sde_pkg::RST_SMOOTH_CAP;
            cfg_reg.smooth_slope           <= sde_pkg::RST_SMOOTH_SLOPE;
            cfg_reg.occluded_match_penalty <= sde_pkg::RST_OCC_PENALTY;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                sde_pkg::REG_OUTLIER_WEIGHT:  cfg_reg.outlier_weight         <= cfg_data;
                sde_pkg::REG_INV_COLOR_SCALE: cfg_reg.inverse_color_scale    <= cfg_data;
                sde_pkg::REG_SMOOTH_CAP:      cfg_reg.smooth_cap             <= cfg_data;
                sde_pkg::REG_SMOOTH_SLOPE:    cfg_reg.smooth_slope           <= cfg_data;
                sde_pkg::REG_OCC_PENALTY:     cfg_reg.occluded_match_penalty <= cfg_data;
                default: ;
            endcase
        end
    end

    sde_front #(
        .LABEL_COUNT(LABEL_COUNT)
    ) u_front (
        .factor_kind    (factor_kind),
        .label_a        (label_a),
        .label_b        (label_b),
        .own_red        (own_red),
        .own_green      (own_green),
        .own_blue       (own_blue),
        .match_red      (match_red),
        .match_green    (match_green),
        .match_blue     (match_blue),
        .pixel_visible  (pixel_visible),
        .match_occluded (match_occluded),
        .same_occlusion (same_occlusion),
        .cfg            (cfg_reg),
        .item           (front_item)
    );

    sde_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_valid && in_ready),
        .push_item  (front_item),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    sde_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .energy     (energy)
    );

endmodule
